// File: rtl/lcdnb_pkg.sv
`timescale 1ns / 1ps

package lcdnb_pkg;

    localparam int ROWS       = 2;
    localparam int COLUMNS    = 16;
    localparam int CELL_COUNT = 32;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS + 1);
    localparam int POS_W      = $clog2(COLUMNS + 1);
    localparam int IDX_W      = 7;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 2;

    // action codes
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_WR_INSTR = 3'd1;
    localparam logic [2:0] ACT_WR_DATA = 3'd2;
    localparam logic [2:0] ACT_INIT    = 3'd3;
    localparam logic [2:0] ACT_STORE   = 3'd4;
    localparam logic [2:0] ACT_REFRESH = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_ON     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_LONG    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SHORT   = 2'd3;

    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
    localparam logic [7:0] ROW1_ADDR        = 8'h40;
    localparam logic [7:0] CHAR_SPACE       = 8'h20;
    localparam logic [3:0] NIB_INIT         = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WAIT_POWER,
        PH_NIB,
        PH_WAIT_LONG,
        PH_WAIT_SHORT,
        PH_HI,
        PH_LO_SET,
        PH_LO,
        PH_POLL_RAISE,
        PH_POLL_READ
    } phase_t;

    typedef enum logic [1:0] {
        JOB_SINGLE,
        JOB_INIT,
        JOB_REFRESH
    } job_t;

    typedef struct packed {
        logic [TICK_W-1:0] init_short_ticks;
        logic [TICK_W-1:0] init_long_ticks;
        logic [TICK_W-1:0] power_on_ticks;
        logic [TICK_W-1:0] enable_pulse_ticks;
    } cfg_t;

    // pin_rs in bit 0
    typedef struct packed {
        logic       rejected;
        logic       idle;
        logic [3:0] pin_data;
        logic       pin_e;
        logic       pin_rw;
        logic       pin_rs;
    } result_t;

    function automatic logic [7:0] init_byte(input logic [3:0] step);
        logic [7:0] b;
        case (step)
            4'd4:    b = CMD_FUNCTION_SET;
            4'd5:    b = CMD_DISPLAY_ON;
            4'd6:    b = CMD_ENTRY_MODE;
            4'd7:    b = CMD_CLEAR;
            default: b = CMD_SET_DDRAM;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/lcdnb_cell_ram.sv
`timescale 1ns / 1ps

module lcdnb_cell_ram (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [lcdnb_pkg::CELL_AW-1:0] waddr,
    input  logic [7:0]                  wdata,
    input  logic [lcdnb_pkg::CELL_AW-1:0] raddr,
    output logic [7:0]                  rdata
);

    logic [7:0] mem [lcdnb_pkg::CELL_COUNT];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/lcdnb_seq.sv
`timescale 1ns / 1ps

module lcdnb_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic [2:0]            in_action,
    input  logic [7:0]            in_byte,
    input  logic [4:0]            in_cell,
    input  logic [3:0]            in_bus,
    input  lcdnb_pkg::cfg_t       cfg,
    output lcdnb_pkg::result_t    result
);

    lcdnb_pkg::phase_t phase_reg, phase_next;
    lcdnb_pkg::job_t   job_reg, job_next;
    logic [lcdnb_pkg::TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [lcdnb_pkg::TICK_W-1:0] tick_inc;
    logic [7:0]  pending_byte_reg, pending_byte_next;
    logic        pending_select_reg, pending_select_next;
    logic [3:0]  init_step_reg, init_step_next;
    logic [lcdnb_pkg::POS_W-1:0] position_reg, position_next;
    logic [lcdnb_pkg::ROW_W-1:0] row_reg, row_next;
    logic        zero_seen_reg, zero_seen_next;
    logic        rs_reg, rs_next, rw_reg, rw_next, e_reg, e_next;
    logic [3:0]  data_reg, data_next;
    logic        rejected;

    logic        sb_go, sb_rs, sn_go;
    logic [7:0]  sb_byte;
    logic [3:0]  sn_nib;
    logic [7:0]  cell_value;

    logic [lcdnb_pkg::IDX_W-1:0] cell_idx;
    logic        cell_in_range;
    logic        ram_we;
    logic [7:0]  ram_rdata;

    // The next refresh cell address is held steady from the previous byte write until it
    // is used, so the RAM is read there every cycle and the data is ready in time.
    assign cell_idx = lcdnb_pkg::IDX_W'(row_reg) * lcdnb_pkg::IDX_W'(lcdnb_pkg::COLUMNS)
                    + lcdnb_pkg::IDX_W'(position_reg);
    assign cell_in_range = cell_idx < lcdnb_pkg::IDX_W'(lcdnb_pkg::CELL_COUNT);
    assign ram_we = in_accept && (in_action == lcdnb_pkg::ACT_STORE)
                    && (phase_reg == lcdnb_pkg::PH_IDLE);

    lcdnb_cell_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_cell[lcdnb_pkg::CELL_AW-1:0]),
        .wdata (in_byte),
        .raddr (cell_idx[lcdnb_pkg::CELL_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign tick_inc = tick_count_reg + 1'b1;

    always_comb begin
        phase_next          = phase_reg;
        job_next            = job_reg;
        tick_count_next     = tick_count_reg;
        pending_byte_next   = pending_byte_reg;
        pending_select_next = pending_select_reg;
        init_step_next      = init_step_reg;
        position_next       = position_reg;
        row_next            = row_reg;
        zero_seen_next      = zero_seen_reg;
        rs_next             = rs_reg;
        rw_next             = rw_reg;
        e_next              = e_reg;
        data_next           = data_reg;
        rejected            = 1'b0;
        sb_go               = 1'b0;
        sb_rs               = 1'b0;
        sb_byte             = 8'h00;
        sn_go               = 1'b0;
        sn_nib              = 4'h0;
        cell_value          = 8'h00;

        if (in_accept) begin
            case (in_action)
                lcdnb_pkg::ACT_TICK: begin
                    case (phase_reg)
                        lcdnb_pkg::PH_WAIT_POWER: begin
                            tick_count_next = tick_inc;
                            if (tick_inc >= cfg.power_on_ticks) begin
                                init_step_next = 4'd1;
                                sn_go = 1'b1;
                                sn_nib = lcdnb_pkg::NIB_INIT;
                            end
                        end
                        lcdnb_pkg::PH_WAIT_LONG: begin
                            tick_count_next = tick_inc;
                            if (tick_inc >= cfg.init_long_ticks) begin
                                init_step_next = 4'd2;
                                sn_go = 1'b1;
                                sn_nib = lcdnb_pkg::NIB_INIT;
                            end
                        end
                        lcdnb_pkg::PH_WAIT_SHORT: begin
                            tick_count_next = tick_inc;
                            if (tick_inc >= cfg.init_short_ticks) begin
                                init_step_next = 4'd3;
                                sn_go = 1'b1;
                                sn_nib = lcdnb_pkg::NIB_INIT;
                            end
                        end
                        lcdnb_pkg::PH_NIB: begin
                            tick_count_next = tick_inc;
                            if (tick_inc >= cfg.enable_pulse_ticks) begin
                                e_next = 1'b0;
                                tick_count_next = '0;
                                if (init_step_reg == 4'd1) begin
                                    phase_next = lcdnb_pkg::PH_WAIT_LONG;
                                end else if (init_step_reg == 4'd2) begin
                                    phase_next = lcdnb_pkg::PH_WAIT_SHORT;
                                end else begin
                                    phase_next = lcdnb_pkg::PH_POLL_RAISE;
                                end
                            end
                        end
                        lcdnb_pkg::PH_HI: begin
                            tick_count_next = tick_inc;
                            if (tick_inc >= cfg.enable_pulse_ticks) begin
                                e_next = 1'b0;
                                data_next = pending_byte_reg[3:0];
                                phase_next = lcdnb_pkg::PH_LO_SET;
                            end
                        end
                        lcdnb_pkg::PH_LO_SET: begin
                            e_next = 1'b1;
                            tick_count_next = '0;
                            phase_next = lcdnb_pkg::PH_LO;
                        end
                        lcdnb_pkg::PH_LO: begin
                            tick_count_next = tick_inc;
                            if (tick_inc >= cfg.enable_pulse_ticks) begin
                                e_next = 1'b0;
                                phase_next = lcdnb_pkg::PH_POLL_RAISE;
                            end
                        end
                        lcdnb_pkg::PH_POLL_RAISE: begin
                            rs_next = 1'b0;
                            rw_next = 1'b1;
                            e_next = 1'b1;
                            phase_next = lcdnb_pkg::PH_POLL_READ;
                        end
                        lcdnb_pkg::PH_POLL_READ: begin
                            e_next = 1'b0;
                            rw_next = 1'b0;
                            if (in_bus[3]) begin
                                phase_next = lcdnb_pkg::PH_POLL_RAISE;
                            end else begin
                                // byte or nibble finished: pick the next unit of the job
                                case (job_reg)
                                    lcdnb_pkg::JOB_INIT: begin
                                        if (init_step_reg == 4'd3) begin
                                            init_step_next = 4'd4;
                                            sn_go = 1'b1;
                                            sn_nib = lcdnb_pkg::NIB_FOUR_BIT;
                                        end else if (init_step_reg >= 4'd4 &&
                                                     init_step_reg < 4'd9) begin
                                            init_step_next = init_step_reg + 4'd1;
                                            sb_go = 1'b1;
                                            sb_byte = lcdnb_pkg::init_byte(init_step_reg);
                                        end else begin
                                            phase_next = lcdnb_pkg::PH_IDLE;
                                        end
                                    end
                                    lcdnb_pkg::JOB_REFRESH: begin
                                        if (position_reg <
                                            lcdnb_pkg::POS_W'(lcdnb_pkg::COLUMNS)) begin
                                            if (!zero_seen_reg && cell_in_range) begin
                                                cell_value = ram_rdata;
                                            end
                                            sb_byte = cell_value;
                                            if (cell_value == 8'h00) begin
                                                zero_seen_next = 1'b1;
                                                sb_byte = lcdnb_pkg::CHAR_SPACE;
                                            end
                                            position_next = position_reg + 1'b1;
                                            sb_go = 1'b1;
                                            sb_rs = 1'b1;
                                        end else begin
                                            row_next = row_reg + 1'b1;
                                            if (row_next <
                                                lcdnb_pkg::ROW_W'(lcdnb_pkg::ROWS)) begin
                                                position_next = '0;
                                                sb_go = 1'b1;
                                                sb_byte = row_next[0]
                                                    ? (lcdnb_pkg::CMD_SET_DDRAM |
                                                       lcdnb_pkg::ROW1_ADDR)
                                                    : lcdnb_pkg::CMD_SET_DDRAM;
                                            end else begin
                                                phase_next = lcdnb_pkg::PH_IDLE;
                                            end
                                        end
                                    end
                                    default: begin
                                        phase_next = lcdnb_pkg::PH_IDLE;
                                    end
                                endcase
                            end
                        end
                        default: begin
                            phase_next = lcdnb_pkg::PH_IDLE;
                        end
                    endcase
                end
                lcdnb_pkg::ACT_WR_INSTR, lcdnb_pkg::ACT_WR_DATA, lcdnb_pkg::ACT_INIT,
                lcdnb_pkg::ACT_STORE, lcdnb_pkg::ACT_REFRESH: begin
                    if (phase_reg != lcdnb_pkg::PH_IDLE) begin
                        rejected = 1'b1;
                    end else begin
                        case (in_action)
                            lcdnb_pkg::ACT_WR_INSTR, lcdnb_pkg::ACT_WR_DATA: begin
                                job_next = lcdnb_pkg::JOB_SINGLE;
                                sb_go = 1'b1;
                                sb_rs = (in_action == lcdnb_pkg::ACT_WR_DATA);
                                sb_byte = in_byte;
                            end
                            lcdnb_pkg::ACT_INIT: begin
                                job_next = lcdnb_pkg::JOB_INIT;
                                init_step_next = 4'd0;
                                rs_next = 1'b0;
                                rw_next = 1'b0;
                                e_next = 1'b0;
                                tick_count_next = '0;
                                phase_next = lcdnb_pkg::PH_WAIT_POWER;
                            end
                            lcdnb_pkg::ACT_REFRESH: begin
                                job_next = lcdnb_pkg::JOB_REFRESH;
                                row_next = '0;
                                zero_seen_next = 1'b0;
                                position_next = '0;
                                sb_go = 1'b1;
                                sb_byte = lcdnb_pkg::CMD_SET_DDRAM;
                            end
                            default: begin
                                // store: written through the RAM port
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end

        if (sb_go) begin
            pending_select_next = sb_rs;
            pending_byte_next = sb_byte;
            rs_next = sb_rs;
            rw_next = 1'b0;
            e_next = 1'b1;
            data_next = sb_byte[7:4];
            tick_count_next = '0;
            phase_next = lcdnb_pkg::PH_HI;
        end
        if (sn_go) begin
            rs_next = 1'b0;
            rw_next = 1'b0;
            e_next = 1'b1;
            data_next = sn_nib;
            tick_count_next = '0;
            phase_next = lcdnb_pkg::PH_NIB;
        end
    end

    always_comb begin
        result.pin_rs   = rs_next;
        result.pin_rw   = rw_next;
        result.pin_e    = e_next;
        result.pin_data = data_next;
        result.idle     = (phase_next == lcdnb_pkg::PH_IDLE);
        result.rejected = rejected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= lcdnb_pkg::PH_IDLE;
            job_reg            <= lcdnb_pkg::JOB_SINGLE;
            tick_count_reg     <= '0;
            pending_byte_reg   <= '0;
            pending_select_reg <= 1'b0;
            init_step_reg      <= '0;
            position_reg       <= '0;
            row_reg            <= '0;
            zero_seen_reg      <= 1'b0;
            rs_reg             <= 1'b0;
            rw_reg             <= 1'b0;
            e_reg              <= 1'b0;
            data_reg           <= '0;
        end else begin
            phase_reg          <= phase_next;
            job_reg            <= job_next;
            tick_count_reg     <= tick_count_next;
            pending_byte_reg   <= pending_byte_next;
            pending_select_reg <= pending_select_next;
            init_step_reg      <= init_step_next;
            position_reg       <= position_next;
            row_reg            <= row_next;
            zero_seen_reg      <= zero_seen_next;
            rs_reg             <= rs_next;
            rw_reg             <= rw_next;
            e_reg              <= e_next;
            data_reg           <= data_next;
        end
    end

endmodule

// File: rtl/lcdnb_out_skid.sv
`timescale 1ns / 1ps

module lcdnb_out_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  lcdnb_pkg::result_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lcdnb_pkg::result_t  out_data
);

    logic               main_valid_reg, main_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    lcdnb_pkg::result_t main_data_reg, main_data_next;
    lcdnb_pkg::result_t skid_data_reg, skid_data_next;
    logic               take_in;

    assign in_ready  = !skid_valid_reg;
    assign take_in   = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || out_ready) begin
            // output slot frees: refill from the skid stage first
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                main_valid_next = 1'b1;
            end else begin
                main_data_next  = in_data;
                main_valid_next = take_in;
            end
            skid_valid_next = 1'b0;
        end else if (take_in) begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: rtl/char_lcd_nibble_bus_driver.sv
`timescale 1ns / 1ps

// Character LCD driver for a 4-bit bus (RS, RW, E, DB7..DB4).
// Input stream: s_tuser carries the action (tick, write instruction, write
// data, initialise, store cell, refresh screen); s_tdata the byte, cell
// index and sampled data pins. Each tick transaction advances the pin
// sequencer by one step; requests start a byte write, the power-on
// sequence, a store into the 32-cell screen RAM or a screen refresh.
// Every input transaction yields exactly one output transaction with the
// pin levels after it, plus idle and rejected flags.
// Output: each result is registered in the output stage before it appears on m_*.
// Throughput: one transaction per clock while s_tready is high; the screen RAM read
// for a refresh is issued ahead from the held cell position, so the registered
// RAM read never stalls the stream.
// Reset: all pins low, sequencer idle, registers back to their defaults.
// Screen cells hold nothing defined until stored.
// Stalls: the output stage holds up to two results; with both full,
// s_tready drops until the receiver takes one.
// Configuration: cfg_* writes are always taken; write only while idle.
module char_lcd_nibble_bus_driver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // byte_value[7:0], cell_index[12:8], bus_read[16:13]
    input  logic [2:0]  s_tuser,  // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // pin_rs[0], pin_rw[1], pin_e[2], pin_data[6:3],
                                  // idle[7], rejected[8]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [lcdnb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    lcdnb_pkg::cfg_t    cfg_reg, cfg_next;
    lcdnb_pkg::result_t seq_result, out_result;
    logic               in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                lcdnb_pkg::REG_ENABLE_PULSE: cfg_next.enable_pulse_ticks = cfg_data;
                lcdnb_pkg::REG_POWER_ON:     cfg_next.power_on_ticks     = cfg_data;
                lcdnb_pkg::REG_INIT_LONG:    cfg_next.init_long_ticks    = cfg_data;
                lcdnb_pkg::REG_INIT_SHORT:   cfg_next.init_short_ticks   = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable_pulse_ticks <= 16'd500;
            cfg_reg.power_on_ticks     <= 16'd10000;
            cfg_reg.init_long_ticks    <= 16'd2500;
            cfg_reg.init_short_ticks   <= 16'd100;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lcdnb_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_action (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_cell   (s_tdata[12:8]),
        .in_bus    (s_tdata[16:13]),
        .cfg       (cfg_reg),
        .result    (seq_result)
    );

    lcdnb_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (seq_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {7'b0, out_result};

endmodule
